>>> hdl/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types and constants of the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned NumWidth  = 16;
   localparam int unsigned DivStages = 4;
   localparam int unsigned HueWrap   = 180;

   localparam logic [6:0] BaseRed   = 7'd0;
   localparam logic [6:0] BaseGreen = 7'd60;
   localparam logic [6:0] BaseBlue  = 7'd120;

   // classified pixel handed from the front to the dividers
   typedef struct packed {
      logic [NumWidth-1:0]  sat_num;   // 255 * delta
      logic [NumWidth-1:0]  hue_num;   // 30 * |diff|, shifted left by 3
      logic [ChanWidth-1:0] sat_den;   // max
      logic [ChanWidth-1:0] hue_den;   // delta
      logic                 neg;       // diff below zero
      logic [6:0]           base;
      logic                 gray;      // max equals min (black included)
      logic [ChanWidth-1:0] max_val;
   } item_type;

endpackage

>>> hdl/rhsv_front.sv
// ----------------------------------------------------------------------------
// rhsv_front
// Accepts pixels, finds max and min, picks the hue sector and forms the
// numerators and divisors for the two divisions.
// ----------------------------------------------------------------------------
module rhsv_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         red,
   input  logic [7:0]         green,
   input  logic [7:0]         blue,
   output logic               out_valid,
   input  logic               out_ready,
   output rhsv_pkg::item_type out_item
);

   logic               valid_ff, valid_in;
   rhsv_pkg::item_type item_ff, item_in;
   logic [7:0]         mx, mn, delta;
   logic signed [8:0]  diff;
   logic [7:0]         mag;
   logic [12:0]        prod_h;
   logic [6:0]         base;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // classify the pixel: red wins ties, then green
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
      if (mx == red) begin
         diff = $signed({1'b0, green}) - $signed({1'b0, blue});
         base = rhsv_pkg::BaseRed;
      end else if (mx == green) begin
         diff = $signed({1'b0, blue}) - $signed({1'b0, red});
         base = rhsv_pkg::BaseGreen;
      end else begin
         diff = $signed({1'b0, red}) - $signed({1'b0, green});
         base = rhsv_pkg::BaseBlue;
      end
      mag    = diff[8] ? 8'(-diff) : diff[7:0];
      prod_h = {mag, 5'd0} - {4'd0, mag, 1'b0};
      item_in.sat_num = {delta, 8'd0} - {8'd0, delta};
      item_in.hue_num = {prod_h, 3'd0};
      item_in.sat_den = mx;
      item_in.hue_den = delta;
      item_in.neg     = diff[8];
      item_in.base    = base;
      item_in.gray    = (mx == mn);
      item_in.max_val = mx;
   end

   // hold the beat until the queue takes it
   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) item_ff <= item_in;
   end

endmodule

>>> hdl/rhsv_queue.sv
// ----------------------------------------------------------------------------
// rhsv_queue
// Two-entry queue between the front and the divider pipeline.
// ----------------------------------------------------------------------------
module rhsv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rhsv_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output rhsv_pkg::item_type out_item
);

   rhsv_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_item;
   end

endmodule

>>> hdl/rhsv_back.sv
// ----------------------------------------------------------------------------
// rhsv_back
// Pipelined restoring dividers, two quotient bits per stage, for saturation
// and hue, followed by the hue sector fix-up and the output register.
// ----------------------------------------------------------------------------
module rhsv_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rhsv_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         hue,
   output logic [7:0]         saturation,
   output logic [7:0]         brightness
);

   typedef struct packed {
      logic                 valid;
      logic [7:0]           rem_s;
      logic [7:0]           quo_s;
      logic [7:0]           bits_s;
      logic [7:0]           rem_h;
      logic [7:0]           quo_h;
      logic [7:0]           bits_h;
      logic [7:0]           den_s;
      logic [7:0]           den_h;
      logic                 neg;
      logic [6:0]           base;
      logic                 gray;
      logic [7:0]           max_val;
   } stage_type;

   stage_type st_ff [rhsv_pkg::DivStages];
   stage_type st_in [rhsv_pkg::DivStages];
   logic       advance;
   logic       out_valid_ff;
   logic [7:0] hue_ff, sat_ff, bri_ff;
   logic [7:0] hue_in, sat_in;
   logic [4:0] hq;
   logic       inexact;
   logic signed [8:0] hsum;

   // one restoring step: shift in a numerator bit, subtract when it fits
   function automatic logic [8:0] div_step(input logic [7:0] r, input logic nb,
                                           input logic [7:0] d);
      logic [8:0] t;
      t = {r, nb};
      if (t >= {1'b0, d}) div_step = {1'b1, 8'(t - {1'b0, d})};
      else div_step = {1'b0, t[7:0]};
   endfunction

   function automatic stage_type two_steps(input stage_type s);
      stage_type  o;
      logic [8:0] a;
      o = s;
      for (int k = 0; k < 2; k++) begin
         a       = div_step(o.rem_s, o.bits_s[7], o.den_s);
         o.rem_s = a[7:0];
         o.quo_s = {o.quo_s[6:0], a[8]};
         o.bits_s = {o.bits_s[6:0], 1'b0};
         a       = div_step(o.rem_h, o.bits_h[7], o.den_h);
         o.rem_h = a[7:0];
         o.quo_h = {o.quo_h[6:0], a[8]};
         o.bits_h = {o.bits_h[6:0], 1'b0};
      end
      two_steps = o;
   endfunction

   assign advance    = !out_valid_ff || out_ready;
   assign in_ready   = advance;
   assign out_valid  = out_valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bri_ff;

   // load the first stage, the high numerator byte is below the divisor
   always_comb begin
      stage_type ld;
      ld.valid   = in_valid;
      ld.rem_s   = in_item.sat_num[15:8];
      ld.quo_s   = 8'd0;
      ld.bits_s  = in_item.sat_num[7:0];
      ld.rem_h   = in_item.hue_num[15:8];
      ld.quo_h   = 8'd0;
      ld.bits_h  = in_item.hue_num[7:0];
      ld.den_s   = in_item.sat_den;
      ld.den_h   = in_item.hue_den;
      ld.neg     = in_item.neg;
      ld.base    = in_item.base;
      ld.gray    = in_item.gray;
      ld.max_val = in_item.max_val;
      st_in[0] = two_steps(ld);
      for (int i = 1; i < rhsv_pkg::DivStages; i++) st_in[i] = two_steps(st_ff[i-1]);
   end

   // hue: quotient of 8*num carries three extra low bits; floor for negatives
   always_comb begin
      stage_type l;
      l       = st_ff[rhsv_pkg::DivStages-1];
      hq      = l.quo_h[7:3];
      inexact = (l.rem_h != 8'd0) || (l.quo_h[2:0] != 3'd0);
      if (l.neg) hsum = $signed({2'b0, l.base}) - $signed({4'b0, hq})
                        - $signed({8'b0, inexact});
      else hsum = $signed({2'b0, l.base}) + $signed({4'b0, hq});
      if (hsum < 0) hsum = hsum + 9'sd180;
      hue_in = hsum[7:0];
      sat_in = l.quo_s;
      if (l.gray) begin
         hue_in = 8'd0;
         sat_in = 8'd0;
      end
   end

   // advance the pipeline; payload moves with the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rhsv_pkg::DivStages; i++) st_ff[i].valid <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < rhsv_pkg::DivStages; i++) st_ff[i] <= st_in[i];
         out_valid_ff <= st_ff[rhsv_pkg::DivStages-1].valid;
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bri_ff <= st_ff[rhsv_pkg::DivStages-1].max_val;
      end
   end

endmodule

>>> hdl/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Converts 8-bit RGB pixels to 8-bit HSV (hue in two-degree units).
// ----------------------------------------------------------------------------
// Takes one pixel per clock while req_tready is high and gives one result per
// pixel, in order. The classification register loads at the accepting edge;
// the result then passes through the two-entry queue, four stages of the
// restoring dividers (two quotient bits each) and the output register.
// Saturation is floor(255*(max-min)/max), hue is the sector base plus
// floor(30*diff/delta) wrapped into 0..179, and gray or black pixels give
// zero hue and saturation.
module rgb_to_hsv_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);

   logic               f_valid, f_ready, q_valid, q_ready;
   rhsv_pkg::item_type f_item, q_item;
   logic [7:0]         hue, sat, bri;

   rhsv_front u_front (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready),
      .red (req_tdata[7:0]), .green (req_tdata[15:8]), .blue (req_tdata[23:16]),
      .out_valid (f_valid), .out_ready (f_ready), .out_item (f_item)
   );

   rhsv_queue u_queue (
      .clock, .reset,
      .in_valid (f_valid), .in_ready (f_ready), .in_item (f_item),
      .out_valid (q_valid), .out_ready (q_ready), .out_item (q_item)
   );

   rhsv_back u_back (
      .clock, .reset,
      .in_valid (q_valid), .in_ready (q_ready), .in_item (q_item),
      .out_valid (rsp_tvalid), .out_ready (rsp_tready),
      .hue (hue), .saturation (sat), .brightness (bri)
   );

   assign rsp_tdata = {bri, sat, hue};

endmodule

>>> hdl/rhsv_checker.sv
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks of the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // hue stays below the wrap point
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] < 8'd180)
      else $error("hue out of range");

   // zero saturation only for gray pixels, which have zero hue
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:8] == 8'd0 |-> rsp_tdata[7:0] == 8'd0)
      else $error("hue set on a gray pixel");

   // black pixel gives zero saturation
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:16] == 8'd0 |-> rsp_tdata[15:8] == 8'd0)
      else $error("saturation set on a black pixel");

endmodule

bind rgb_to_hsv_pixel rhsv_checker u_rhsv_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
